// ===== rtl/nscc_pkg.sv =====
// ============================================================================
// NMEA sentence checksum checker package
// Shared types, character codes and the byte classifier.
// ============================================================================
`default_nettype none

package nscc_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_CR    = 8'h0D;  // carriage return

  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] UPPER_BASE = 8'h37;
  localparam logic [7:0] LOWER_BASE = 8'h57;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_STAR,
    CLS_CR,
    CLS_HEX,
    CLS_OTHER
  } byte_class_t;

  typedef enum logic [1:0] {
    STAT_VALID     = 2'd0,
    STAT_MISMATCH  = 2'd1,
    STAT_BAD_DIGIT = 2'd2
  } sentence_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BODY,
    ST_DIGITS
  } parse_state_t;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    byte_class_t cls;
    logic [3:0]  nibble;
    logic [7:0]  data;
  } token_t;

  function automatic token_t classify(input logic [7:0] c);
    token_t     t;
    logic [7:0] diff;
    t.data   = c;
    t.nibble = 4'd0;
    diff     = 8'd0;
    if (c == CH_START) begin
      t.cls = CLS_START;
    end else if (c == CH_STAR) begin
      t.cls = CLS_STAR;
    end else if (c == CH_CR) begin
      t.cls = CLS_CR;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t.cls = CLS_HEX;
      diff  = c - DIGIT_BASE;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t.cls = CLS_HEX;
      diff  = c - UPPER_BASE;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t.cls = CLS_HEX;
      diff  = c - LOWER_BASE;
    end else begin
      t.cls = CLS_OTHER;
    end
    t.nibble = diff[3:0];
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nscc_if.sv =====
// ============================================================================
// NMEA sentence checksum checker channels
// Valid/ready channels for received bytes and for sentence results.
// ============================================================================
`default_nettype none

interface nscc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nscc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_status;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (output valid, output sentence_status, output computed_sum,
                  output received_sum, input ready);
  modport sink (input valid, input sentence_status, input computed_sum,
                input received_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/nscc_front.sv =====
// ============================================================================
// NMEA checker front end
// Accepts received bytes and classifies them into tokens for the queue.
// ============================================================================
`default_nettype none

module nscc_front (
  nscc_in_if.sink         in_ch,
  input  wire logic       q_full,
  output nscc_pkg::token_t push_token,
  output logic            push
);
  import nscc_pkg::*;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign push_token  = classify(in_ch.rx_byte);

endmodule

`default_nettype wire

// ===== rtl/nscc_queue.sv =====
// ============================================================================
// NMEA checker token queue
// Small register FIFO that decouples the front end from the back end.
// ============================================================================
`default_nettype none

module nscc_queue #(
  parameter int Depth = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire nscc_pkg::token_t  push_token,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output nscc_pkg::token_t       head
);
  import nscc_pkg::*;

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  token_t          slot_r [Depth];
  logic [IdxW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IdxW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == FullCnt);
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nscc_back.sv =====
// ============================================================================
// NMEA checker back end
// Sentence parser: running XOR, digit field, and the result register.
// ============================================================================
`default_nettype none

module nscc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_not_empty,
  input  wire nscc_pkg::token_t q_head,
  output logic                  pop,
  nscc_out_if.source            out_ch
);
  import nscc_pkg::*;

  parse_state_t     state_r, state_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       digits_r, digits_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  sentence_status_t status_r;
  logic [7:0]       computed_r;
  logic [7:0]       received_r;
  sentence_status_t status_nxt;
  logic             closes;
  logic             slot_free;
  logic             emit;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign closes    = (q_head.cls == CLS_CR) && (state_r == ST_DIGITS);
  assign pop       = q_not_empty && (!closes || slot_free);
  assign emit      = pop && closes;

  always_comb begin
    state_nxt  = state_r;
    xor_nxt    = xor_r;
    digits_nxt = digits_r;
    bad_nxt    = bad_r;
    if (bad_r) begin
      status_nxt = STAT_BAD_DIGIT;
    end else if (xor_r == digits_r) begin
      status_nxt = STAT_VALID;
    end else begin
      status_nxt = STAT_MISMATCH;
    end
    if (pop) begin
      if (q_head.cls == CLS_START) begin
        state_nxt  = ST_BODY;
        xor_nxt    = '0;
        digits_nxt = '0;
        bad_nxt    = 1'b0;
      end else if (state_r != ST_IDLE) begin
        unique case (q_head.cls)
          CLS_STAR: begin
            state_nxt  = ST_DIGITS;
            digits_nxt = '0;
            bad_nxt    = 1'b0;
          end
          CLS_CR: begin
            if (state_r == ST_DIGITS) begin
              state_nxt  = ST_IDLE;
              xor_nxt    = '0;
              digits_nxt = '0;
              bad_nxt    = 1'b0;
            end
          end
          default: begin
            if (state_r == ST_DIGITS) begin
              if (q_head.cls == CLS_HEX) begin
                digits_nxt = {digits_r[3:0], q_head.nibble};
              end else begin
                bad_nxt = 1'b1;
              end
            end else begin
              xor_nxt = xor_r ^ q_head.data;
            end
          end
        endcase
      end
    end
    out_valid_nxt = (out_valid_r && !out_ch.ready) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      xor_r       <= '0;
      digits_r    <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      xor_r       <= xor_nxt;
      digits_r    <= digits_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r   <= status_nxt;
      computed_r <= xor_r;
      received_r <= digits_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sentence_status = status_r;
  assign out_ch.computed_sum    = computed_r;
  assign out_ch.received_sum    = received_r;

endmodule

`default_nettype wire

// ===== rtl/nmea_sentence_checksum_checker_unit.sv =====
// ============================================================================
// NMEA 0183 sentence checksum checker
// Checks the two-digit hex checksum of sentences received one byte per word.
// ============================================================================
// The unit takes one received character per word on in_ch and gives one word
// on out_ch for every sentence that a carriage return closes after a '*'. A
// '$' opens a sentence and clears the running XOR; body bytes up to the first
// '*' are XORed together, and the hex digits after it (either case) are
// shifted into an eight-bit received value of which only the last two digits
// count. A further '*' restarts the digit field, and a non-hex byte there
// makes the status a bad digit while both sums are still reported. A carriage
// return before any '*', and everything outside a sentence other than '$', is
// dropped silently. Bytes are accepted one per clock cycle for as long as the
// result side keeps up: the front end classifies each word straight into a
// small token queue, and the back end updates its parser state from one token
// every cycle, so the parser state update is what sets the rate. A result
// passes through the token queue and the result register before it appears on
// out_ch. While a result waits to be taken the back end keeps consuming bytes
// and only halts on the next closing return; the queue of QueueDepth tokens
// then fills before in_ch.ready drops.
// ============================================================================
`default_nettype none

module nmea_sentence_checksum_checker_unit #(
  parameter int QueueDepth = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nscc_in_if.sink     in_ch,
  nscc_out_if.source  out_ch
);
  import nscc_pkg::*;

  token_t push_token;
  token_t q_head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_not_empty;

  // Front end: handshake and byte classification.
  nscc_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_token (push_token),
    .push       (push)
  );

  // Queue between the two halves so that each can stall on its own.
  nscc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Back end: sentence parser and registered result.
  nscc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/nscc_checker.sv =====
// ============================================================================
// NMEA checker port assertions
// Checks the result channel of the checker as seen at its ports.
// ============================================================================
`default_nettype none

module nscc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_computed,
  input wire logic [7:0] out_received
);
  import nscc_pkg::*;

  // A stalled result must stay offered.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Reset empties the result register.
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A valid status means the two sums agree.
  a_valid_match : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_VALID) |-> out_computed == out_received)
    else $error("valid status with differing sums");

  // A mismatch status means the two sums differ.
  a_mismatch_differs : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_MISMATCH) |-> out_computed != out_received)
    else $error("mismatch status with equal sums");

  // Only the three defined status codes are ever reported.
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_VALID) || (out_status == STAT_MISMATCH) ||
                  (out_status == STAT_BAD_DIGIT))
    else $error("undefined status code");

endmodule

bind nmea_sentence_checksum_checker_unit nscc_checker u_nscc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.sentence_status),
  .out_computed (out_ch.computed_sum),
  .out_received (out_ch.received_sum)
);

`default_nettype wire
